// ===== hw/rtl/kbt_pkg.sv =====
// kbt_pkg: shared types and codes of the bucket table
// command and status codes, sequencer states and the structs passed between modules
// no dependencies
package kbt_pkg;

   localparam int ID_W     = 64;
   localparam int ADDR_W   = 48;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_OLDEST = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_EXISTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOW  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_HIGH = 1'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK_LOW,
      S_CHK_HIGH,
      S_SCAN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ID_W-1:0]   node_id;
      logic [ADDR_W-1:0] node_address;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     found_id;
      logic [ADDR_W-1:0]   found_address;
      logic [TIME_W-1:0]   found_time;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0] range_low;
      logic [ID_W-1:0] range_high;
   } cfg_type;

   typedef struct packed {
      logic id_eq;
      logic key_lt;
   } cmp_out_type;

endpackage

// ===== hw/rtl/kbt_req_if.sv =====
// kbt_req_if: request channel of the bucket table
// valid/ready handshake with command, node id, address and timestamp
// no dependencies
interface kbt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] node_id;
   logic [47:0] node_address;
   logic [31:0] now_time;

   modport source (output valid, output cmd, output node_id, output node_address,
                   output now_time, input ready);
   modport sink   (input valid, input cmd, input node_id, input node_address,
                   input now_time, output ready);
endinterface

// ===== hw/rtl/kbt_rsp_if.sv =====
// kbt_rsp_if: response channel of the bucket table
// valid/ready handshake with status, returned contact and entry count
// no dependencies
interface kbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] found_id;
   logic [47:0] found_address;
   logic [31:0] found_time;
   logic [3:0]  entry_count;

   modport source (output valid, output status, output found_id, output found_address,
                   output found_time, output entry_count, input ready);
   modport sink   (input valid, input status, input found_id, input found_address,
                   input found_time, input entry_count, output ready);
endinterface

// ===== hw/rtl/kbt_ram.sv =====
// kbt_ram: generic single write port, single read port ram
// registered read data, no reset on contents
// no dependencies
module kbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/kbt_cmp_unit.sv =====
// kbt_cmp_unit: shared compare unit of the bucket table sequencer
// id equality and {time, id} less-than, used for range, lookup and oldest search
// depends on kbt_pkg
module kbt_cmp_unit import kbt_pkg::*; #(
   parameter int TW = 32
) (
   input  logic [TW-1:0]   a_time,
   input  logic [ID_W-1:0] a_id,
   input  logic [TW-1:0]   b_time,
   input  logic [ID_W-1:0] b_id,
   output cmp_out_type     result
);
   assign result.id_eq  = (a_id == b_id);
   assign result.key_lt = ({a_time, a_id} < {b_time, b_id});
endmodule

// ===== hw/rtl/kbt_seq.sv =====
// kbt_seq: sequencer of the bucket table
// holds valid bits and count, scans the contact ram through the shared compare unit
// depends on kbt_pkg, kbt_ram, kbt_cmp_unit
module kbt_seq import kbt_pkg::*; #(
   parameter int BUCKET_SIZE = 8,
   parameter int TIME_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   input  cfg_type cfg,
   output logic    res_valid,
   input  logic    res_ready,
   output rsp_type res
);
   localparam int STW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
   localparam int IDX_W  = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
   localparam int CNT_W  = $clog2(BUCKET_SIZE + 1);
   localparam int WORD_W = ID_W + ADDR_W + STW;

   state_type state_ff, state_in;

   logic [BUCKET_SIZE-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       issue_cnt_ff, issue_cnt_in;
   logic                   pending_ff, pending_in;
   logic [IDX_W-1:0]       eval_idx_ff, eval_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_slot_ff, hit_slot_in;
   logic [ID_W-1:0]        hit_id_ff, hit_id_in;
   logic [ADDR_W-1:0]      hit_addr_ff, hit_addr_in;
   logic [STW-1:0]         hit_time_ff, hit_time_in;
   logic                   free_ff, free_in;
   logic [IDX_W-1:0]       free_slot_ff, free_slot_in;
   logic                   range_bad_ff, range_bad_in;
   req_type                req_ff, req_in;

   logic [IDX_W-1:0]  issue_idx;
   logic              accept;
   logic              commit_fire;
   logic              full;
   logic              set_valid, clr_valid;
   logic [IDX_W-1:0]  commit_slot;
   logic [CNT_W-1:0]  count_after;
   logic [CNT_W+3:0]  count_wide;
   logic [STW+31:0]   time_wide;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;
   logic [ID_W-1:0]   rd_id;
   logic [ADDR_W-1:0] rd_addr;
   logic [STW-1:0]    rd_time;

   logic [STW-1:0]    cu_a_time, cu_b_time;
   logic [ID_W-1:0]   cu_a_id, cu_b_id;
   cmp_out_type       cu_out;

   assign issue_idx = issue_cnt_ff[IDX_W-1:0];
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff >= CNT_W'(BUCKET_SIZE));
   assign rd_id     = ram_rdata[WORD_W-1 -: ID_W];
   assign rd_addr   = ram_rdata[STW+ADDR_W-1 -: ADDR_W];
   assign rd_time   = ram_rdata[STW-1:0];

   kbt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BUCKET_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_idx),
      .rd_data (ram_rdata)
   );

   kbt_cmp_unit #(
      .TW (STW)
   ) u_cmp (
      .a_time (cu_a_time),
      .a_id   (cu_a_id),
      .b_time (cu_b_time),
      .b_id   (cu_b_id),
      .result (cu_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req.cmd == CMD_ADD) ? S_CHK_LOW : S_SCAN;
            end
         end
         S_CHK_LOW: begin
            state_in = S_CHK_HIGH;
         end
         S_CHK_HIGH: begin
            if (range_bad_ff || cu_out.key_lt || full) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_cnt_ff == CNT_W'(BUCKET_SIZE)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs: handshake, compare unit operands, commit decision and ram write
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      res_valid   = (state_ff == S_COMMIT);
      commit_fire = res_valid && res_ready;

      cu_a_time = '0;
      cu_a_id   = req_ff.node_id;
      cu_b_time = '0;
      cu_b_id   = cfg.range_low;
      case (state_ff)
         S_CHK_HIGH: begin
            cu_a_id = cfg.range_high;
            cu_b_id = req_ff.node_id;
         end
         S_SCAN: begin
            cu_a_time = rd_time;
            cu_a_id   = rd_id;
            if (req_ff.cmd == CMD_OLDEST) begin
               cu_b_time = hit_time_ff;
               cu_b_id   = hit_id_ff;
            end else begin
               cu_b_id = req_ff.node_id;
            end
         end
         default: begin
         end
      endcase

      set_valid   = 1'b0;
      clr_valid   = 1'b0;
      commit_slot = hit_slot_ff;
      count_after = count_ff;
      res = '0;
      res.status = STAT_NOTFOUND;
      time_wide = {32'b0, hit_time_ff};
      case (req_ff.cmd)
         CMD_ADD: begin
            if (range_bad_ff) begin
               res.status = STAT_RANGE;
            end else if (full) begin
               res.status = STAT_FULL;
            end else if (hit_ff) begin
               res.status = STAT_EXISTED;
            end else if (free_ff) begin
               res.status  = STAT_OK;
               set_valid   = 1'b1;
               commit_slot = free_slot_ff;
               count_after = count_ff + CNT_W'(1);
            end else begin
               res.status = STAT_FULL;
            end
         end
         CMD_REMOVE: begin
            if (hit_ff) begin
               res.status  = STAT_OK;
               clr_valid   = 1'b1;
               count_after = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (hit_ff) begin
               res.status        = STAT_OK;
               res.found_id      = hit_id_ff;
               res.found_address = hit_addr_ff;
               res.found_time    = time_wide[31:0];
            end
         end
      endcase
      count_wide      = {4'b0000, count_after};
      res.entry_count = count_wide[3:0];

      ram_we    = commit_fire && (req_ff.cmd == CMD_ADD) &&
                  (res.status == STAT_OK || res.status == STAT_EXISTED);
      ram_waddr = commit_slot;
      ram_wdata = {req_ff.node_id, req_ff.node_address, req_ff.now_time[STW-1:0]};
   end

   // datapath next values
   always_comb begin
      valid_in     = valid_ff;
      count_in     = count_ff;
      issue_cnt_in = issue_cnt_ff;
      pending_in   = 1'b0;
      eval_idx_in  = eval_idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_id_in    = hit_id_ff;
      hit_addr_in  = hit_addr_ff;
      hit_time_in  = hit_time_ff;
      free_in      = free_ff;
      free_slot_in = free_slot_ff;
      range_bad_in = range_bad_ff;
      req_in       = req_ff;

      if (accept) begin
         req_in       = req;
         issue_cnt_in = '0;
         hit_in       = 1'b0;
         free_in      = 1'b0;
         range_bad_in = 1'b0;
      end

      if (state_ff == S_CHK_LOW || state_ff == S_CHK_HIGH) begin
         range_bad_in = range_bad_ff || cu_out.key_lt;
      end

      if (state_ff == S_SCAN) begin
         // issue one read per cycle, note the lowest free slot on the way
         if (issue_cnt_ff < CNT_W'(BUCKET_SIZE)) begin
            issue_cnt_in = issue_cnt_ff + CNT_W'(1);
            pending_in   = 1'b1;
            eval_idx_in  = issue_idx;
            if (!valid_ff[issue_idx] && !free_ff) begin
               free_in      = 1'b1;
               free_slot_in = issue_idx;
            end
         end
         // evaluate the entry read in the previous cycle
         if (pending_ff && valid_ff[eval_idx_ff]) begin
            if ((req_ff.cmd == CMD_OLDEST) ? (!hit_ff || cu_out.key_lt)
                                           : (!hit_ff && cu_out.id_eq)) begin
               hit_in      = 1'b1;
               hit_slot_in = eval_idx_ff;
               hit_id_in   = rd_id;
               hit_addr_in = rd_addr;
               hit_time_in = rd_time;
            end
         end
      end

      if (commit_fire) begin
         count_in = count_after;
         if (set_valid) begin
            valid_in[commit_slot] = 1'b1;
         end
         if (clr_valid) begin
            valid_in[commit_slot] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         issue_cnt_ff <= '0;
         pending_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         range_bad_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         issue_cnt_ff <= issue_cnt_in;
         pending_ff   <= pending_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         range_bad_ff <= range_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff  <= eval_idx_in;
      hit_slot_ff  <= hit_slot_in;
      hit_id_ff    <= hit_id_in;
      hit_addr_ff  <= hit_addr_in;
      hit_time_ff  <= hit_time_in;
      free_slot_ff <= free_slot_in;
      req_ff       <= req_in;
   end

   // held count always tracks the valid bits
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("held count differs from number of valid slots");

   // a contact found by the scan sits in a valid slot when the result goes out
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && hit_ff) |-> valid_ff[hit_slot_ff])
      else $error("hit slot is not valid at commit");

   // a free slot found by the scan is really free
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && free_ff) |-> !valid_ff[free_slot_ff])
      else $error("free slot is occupied at commit");

   // a new contact is only added below capacity
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (commit_fire && set_valid) |-> !full)
      else $error("insert into a full bucket");
endmodule

// ===== hw/rtl/kademlia_bucket_table.sv =====
// kademlia_bucket_table: one k-bucket of a kademlia routing table, top level
// holds the range registers and the response register around the sequencer
// depends on kbt_pkg, kbt_req_if, kbt_rsp_if, kbt_seq
//
// The bucket holds up to BUCKET_SIZE contacts (id, address, last-seen time) for
// the id range [range_low, range_high]. Commands: add or refresh, remove, lookup
// and oldest (least last-seen time, ties to the smallest id). One item is worked
// at a time; req ready is high only while the sequencer is idle. An add runs two
// range compare steps, a scan of all BUCKET_SIZE slots and a commit step; an
// add that is out of range or meets a full bucket goes from the range steps
// straight to the commit. Remove, lookup and oldest skip the range steps. The
// scan reads the contact ram one slot per cycle through its single read port
// and feeds a single shared compare unit. A finished result sits in the
// response register, so the next item is taken while it waits; the commit of
// an item waits only while that register is still full. Only the low TIME_BITS
// bits (at most 32) of now_time are stored. Range registers are to be written
// through csr_we / csr_index / csr_wdata while idle; the block itself does not
// enforce this.
module kademlia_bucket_table import kbt_pkg::*; #(
   parameter int BUCKET_SIZE = 8,
   parameter int TIME_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   kbt_req_if.sink                req_ch,
   kbt_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   // range registers
   logic [ID_W-1:0] range_low_ff, range_low_in;
   logic [ID_W-1:0] range_high_ff, range_high_in;
   cfg_type         cfg;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // sequencer hookup
   req_type req_item;
   logic    seq_req_ready;
   logic    seq_res_valid;
   logic    seq_res_ready;
   rsp_type seq_res;

   assign req_item.cmd          = req_ch.cmd;
   assign req_item.node_id      = req_ch.node_id;
   assign req_item.node_address = req_ch.node_address;
   assign req_item.now_time     = req_ch.now_time;
   assign req_ch.ready          = seq_req_ready;

   assign cfg.range_low  = range_low_ff;
   assign cfg.range_high = range_high_ff;

   // result slot is free when empty or being drained this cycle
   assign seq_res_ready = !rsp_valid_ff || rsp_ch.ready;

   kbt_seq #(
      .BUCKET_SIZE (BUCKET_SIZE),
      .TIME_BITS   (TIME_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (seq_req_ready),
      .req       (req_item),
      .cfg       (cfg),
      .res_valid (seq_res_valid),
      .res_ready (seq_res_ready),
      .res       (seq_res)
   );

   // register writes, an index beyond the list is dropped
   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RANGE_LOW: begin
               range_low_in = csr_wdata;
            end
            CSR_RANGE_HIGH: begin
               range_high_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // response register load and drain
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_res_valid && seq_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= '1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_data_ff.status;
   assign rsp_ch.found_id      = rsp_data_ff.found_id;
   assign rsp_ch.found_address = rsp_data_ff.found_address;
   assign rsp_ch.found_time    = rsp_data_ff.found_time;
   assign rsp_ch.entry_count   = rsp_data_ff.entry_count;
endmodule
